// ----- src/aar_pkg.sv -----
// shared constants, types and rounding helper for the axis-angle rotation block
`default_nettype none
package aar_pkg;

  localparam int Q14_ONE = 16384;

  localparam logic [63:0] GAIN_Q32 = 64'd2608131496;

  localparam logic [31:0] ATAN_TURN32 [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  // divide by 2^n, rounding half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int n);
    logic [63:0] mag;
    logic [63:0] half;
    if (n == 0) begin
      return v;
    end
    half = 64'd1 << (n - 1);
    if (!v[63]) begin
      return $signed(($unsigned(v) + half) >> n);
    end
    mag = $unsigned(-v);
    return -$signed((mag + half) >> n);
  endfunction

endpackage
`default_nettype wire

// ----- src/aar_sqrt_cell.sv -----
// one bit of the integer square root chain
`default_nettype none
module aar_sqrt_cell #(
  parameter int BIT = 31,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [63:0]   rem_i,
  input  logic [31:0]   root_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [63:0]   rem_o,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);
  import aar_pkg::*;

  logic [65:0]   trial;
  logic          take;
  logic          vld_r;
  logic [63:0]   rem_r;
  logic [31:0]   root_r;
  logic [SW-1:0] side_r;

  assign trial = ({34'd0, root_i} << (BIT + 1)) | (66'd1 << (2 * BIT));
  assign take  = {2'b00, rem_i} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= take ? rem_i - trial[63:0] : rem_i;
      root_r <= take ? (root_i | (32'd1 << BIT)) : root_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// ----- src/aar_div_cell.sv -----
// one quotient bit of the three-lane restoring divider
`default_nettype none
module aar_div_cell #(
  parameter int K  = 0,
  parameter int FB = 14,
  parameter int NW = 48,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [31:0]          len_i,
  input  logic [2:0][NW-1:0]   rem_i,
  input  logic [2:0][FB:0]     quo_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic [31:0]          len_o,
  output logic [2:0][NW-1:0]   rem_o,
  output logic [2:0][FB:0]     quo_o,
  output logic [SW-1:0]        side_o
);
  import aar_pkg::*;

  logic [NW-1:0]         dvs;
  logic                  vld_r;
  logic [31:0]           len_r;
  logic [2:0][NW-1:0]    rem_r;
  logic [2:0][FB:0]      quo_r;
  logic [SW-1:0]         side_r;

  assign dvs = NW'(len_i) << K;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r  <= len_i;
      side_r <= side_i;
      for (int l = 0; l < 3; l++) begin
        if (rem_i[l] >= dvs) begin
          rem_r[l] <= rem_i[l] - dvs;
          quo_r[l] <= quo_i[l] | ((FB + 1)'(1) << K);
        end else begin
          rem_r[l] <= rem_i[l];
          quo_r[l] <= quo_i[l];
        end
      end
    end
  end

  assign vld_o  = vld_r;
  assign len_o  = len_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// ----- src/aar_cordic_cell.sv -----
// one micro-rotation of the sine/cosine cordic
`default_nettype none
module aar_cordic_cell #(
  parameter int I  = 0,
  parameter int XW = 17,
  parameter int ZW = 34,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [SW-1:0]        side_o
);
  import aar_pkg::*;

  logic signed [ZW-1:0] ang;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 vld_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic [SW-1:0]        side_r;

  assign ang = $signed(ZW'(ATAN_TURN32[I]));
  assign xs  = x_i >>> I;
  assign ys  = y_i >>> I;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      if (!z_i[ZW-1]) begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ang;
      end else begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ang;
      end
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// ----- src/aar_matrix.sv -----
// products and sums of the rotation matrix elements, three stages
`default_nettype none
module aar_matrix #(
  parameter int FB = 14,
  parameter int UW = 16,
  parameter int EW = 19
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  aar_pkg::ctl_t            ctl_i,
  input  logic signed [UW-1:0]     c_i,
  input  logic signed [UW-1:0]     s_i,
  input  logic signed [UW:0]       t_i,
  input  logic signed [UW-1:0]     x_i,
  input  logic signed [UW-1:0]     y_i,
  input  logic signed [UW-1:0]     z_i,
  output aar_pkg::ctl_t            ctl_o,
  output logic [8:0][EW-1:0]       el_o
);
  import aar_pkg::*;

  localparam int PW = EW - 1;

  function automatic logic signed [PW-1:0] mq(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return PW'(rnd_shift(p, FB));
  endfunction

  ctl_t c1_r, c2_r, c3_r;
  logic signed [PW-1:0] tx_r, ty_r, xx_r, yy_r, zz_r, sx_r, sy_r, sz_r;
  logic signed [PW-1:0] tz_r;
  logic signed [PW-1:0] y1_r, z1_r, t1_r, cv1_r;
  logic signed [PW-1:0] txy_r, txz_r, tyz_r, dxx_r, dyy_r, dzz_r;
  logic signed [PW-1:0] sx2_r, sy2_r, sz2_r, cv2_r;
  logic [8:0][EW-1:0]   el_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c1_r <= ctl_i;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r  <= mq(64'(t_i), 64'(x_i));
      ty_r  <= mq(64'(t_i), 64'(y_i));
      tz_r  <= mq(64'(t_i), 64'(z_i));
      xx_r  <= mq(64'(x_i), 64'(x_i));
      yy_r  <= mq(64'(y_i), 64'(y_i));
      zz_r  <= mq(64'(z_i), 64'(z_i));
      sx_r  <= mq(64'(s_i), 64'(x_i));
      sy_r  <= mq(64'(s_i), 64'(y_i));
      sz_r  <= mq(64'(s_i), 64'(z_i));
      y1_r  <= PW'(y_i);
      z1_r  <= PW'(z_i);
      t1_r  <= PW'(t_i);
      cv1_r <= PW'(c_i);

      txy_r <= mq(64'(tx_r), 64'(y1_r));
      txz_r <= mq(64'(tx_r), 64'(z1_r));
      tyz_r <= mq(64'(ty_r), 64'(z1_r));
      dxx_r <= mq(64'(t1_r), 64'(xx_r));
      dyy_r <= mq(64'(t1_r), 64'(yy_r));
      dzz_r <= mq(64'(t1_r), 64'(zz_r));
      sx2_r <= sx_r;
      sy2_r <= sy_r;
      sz2_r <= sz_r;
      cv2_r <= cv1_r;

      el_r[0] <= EW'(dxx_r) + EW'(cv2_r);
      el_r[1] <= EW'(txy_r) + EW'(sz2_r);
      el_r[2] <= EW'(txz_r) - EW'(sy2_r);
      el_r[3] <= EW'(txy_r) - EW'(sz2_r);
      el_r[4] <= EW'(dyy_r) + EW'(cv2_r);
      el_r[5] <= EW'(tyz_r) + EW'(sx2_r);
      el_r[6] <= EW'(txz_r) + EW'(sy2_r);
      el_r[7] <= EW'(tyz_r) - EW'(sx2_r);
      el_r[8] <= EW'(dzz_r) + EW'(cv2_r);
    end
  end

  assign ctl_o = c3_r;
  assign el_o  = el_r;
endmodule
`default_nettype wire

// ----- src/axis_angle_rotation_matrix.sv -----
// throughput: one beat per cycle when not stalled; squares, 32 square root cells, FRACTION_BITS+1
// divider cells, CORDIC_STEPS rotation cells and three matrix stages all advance together
// the pipeline keeps moving while a result waits, as long as its last stage is empty
// reset: synchronous active low rst_n clears all valid bits, no result pending after reset
`default_nettype none
module axis_angle_rotation_matrix #(
  parameter int FRACTION_BITS = 14,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_r00,
  output logic signed [15:0] out_r01,
  output logic signed [15:0] out_r02,
  output logic signed [15:0] out_r10,
  output logic signed [15:0] out_r11,
  output logic signed [15:0] out_r12,
  output logic signed [15:0] out_r20,
  output logic signed [15:0] out_r21,
  output logic signed [15:0] out_r22,
  output logic               out_axis_zero
);
  import aar_pkg::*;

  localparam int FB    = FRACTION_BITS;
  localparam int NS    = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int NW    = FB + 34;
  localparam int UW    = FB + 2;
  localparam int XW    = FB + 3;
  localparam int ZW    = 34;
  localparam int EW    = FB + 5;
  localparam int SSW   = 68;
  localparam int DSW   = 20;
  localparam int CSW   = 3 * UW + 1;
  localparam int LSH   = (FB < 14) ? 14 - FB : 0;
  localparam int RSH   = (FB > 14) ? FB - 14 : 0;
  localparam logic [63:0] X0_FULL = (GAIN_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
  localparam logic signed [XW-1:0] X0  = XW'(X0_FULL);
  localparam logic signed [XW-1:0] ONE = XW'(64'd1 << FB);

  logic adv;
  logic out_free;
  logic out_valid_r;

  // squares
  logic        p1_vld_r;
  logic [31:0] sq_r [0:2];
  logic [15:0] mag_r [0:2];
  logic [2:0]  neg_r;
  logic [15:0] ang1_r;

  // sum
  logic        p2_vld_r;
  logic [31:0] sum_r;
  logic        zero2_r;
  logic [SSW-1:0] side2_r;

  logic            sq_vld  [0:32];
  logic [63:0]     sq_rem  [0:32];
  logic [31:0]     sq_root [0:32];
  logic [SSW-1:0]  sq_side [0:32];

  logic                 dv_vld  [0:FB+1];
  logic [31:0]          dv_len  [0:FB+1];
  logic [2:0][NW-1:0]   dv_rem  [0:FB+1];
  logic [2:0][FB:0]     dv_quo  [0:FB+1];
  logic [DSW-1:0]       dv_side [0:FB+1];

  logic [15:0] sd_mag [0:2];
  logic [2:0]  sd_neg;
  logic [15:0] sd_ang;
  logic        sd_zero;

  logic                  u_vld_r;
  logic signed [UW-1:0]  u_r [0:2];
  logic [15:0]           u_ang_r;
  logic                  u_zero_r;
  logic [2:0]            dd_neg;

  logic [15:0] aq;
  logic [1:0]  quad;
  logic [15:0] resid;

  logic                  cr_vld  [0:NS];
  logic signed [XW-1:0]  cr_x    [0:NS];
  logic signed [XW-1:0]  cr_y    [0:NS];
  logic signed [ZW-1:0]  cr_z    [0:NS];
  logic [CSW+1:0]        cr_side [0:NS];

  logic signed [XW-1:0] cc;
  logic signed [XW-1:0] ss;
  logic signed [XW-1:0] cl_c;
  logic signed [XW-1:0] cl_s;
  logic [1:0]           cq;

  ctl_t                 q_ctl_r;
  logic signed [UW-1:0] q_c_r, q_s_r, q_x_r, q_y_r, q_z_r;
  logic signed [UW:0]   q_t_r;

  ctl_t                 m_ctl;
  logic [8:0][EW-1:0]   m_el;

  logic signed [15:0]   res_r [0:8];
  logic                 zero_out_r;
  logic signed [15:0]   res_nxt [0:8];

  assign out_free = !out_valid_r || out_ready;
  assign adv      = out_free || !m_ctl.vld;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_valid;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0]  <= 32'(in_axis_x * in_axis_x);
      sq_r[1]  <= 32'(in_axis_y * in_axis_y);
      sq_r[2]  <= 32'(in_axis_z * in_axis_z);
      mag_r[0] <= in_axis_x[15] ? 16'(-in_axis_x) : in_axis_x;
      mag_r[1] <= in_axis_y[15] ? 16'(-in_axis_y) : in_axis_y;
      mag_r[2] <= in_axis_z[15] ? 16'(-in_axis_z) : in_axis_z;
      neg_r    <= {in_axis_z[15], in_axis_y[15], in_axis_x[15]};
      ang1_r   <= in_angle;
      sum_r    <= sq_r[0] + sq_r[1] + sq_r[2];
      zero2_r  <= (mag_r[0] == 16'd0) && (mag_r[1] == 16'd0) && (mag_r[2] == 16'd0);
      side2_r  <= {ang1_r, neg_r, mag_r[2], mag_r[1], mag_r[0], 1'b0};
    end
  end

  // square root of sum * 2^32
  assign sq_vld[0]  = p2_vld_r;
  assign sq_rem[0]  = {sum_r, 32'd0};
  assign sq_root[0] = 32'd0;
  assign sq_side[0] = {side2_r[SSW-1:1], zero2_r};

  for (genvar g = 0; g < 32; g++) begin : g_sqrt
    aar_sqrt_cell #(.BIT(31 - g), .SW(SSW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(sq_vld[g]), .rem_i(sq_rem[g]), .root_i(sq_root[g]), .side_i(sq_side[g]),
      .vld_o(sq_vld[g+1]), .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1]),
      .side_o(sq_side[g+1])
    );
  end

  // division of each scaled magnitude by the length
  assign sd_zero   = sq_side[32][0];
  assign sd_mag[0] = sq_side[32][16:1];
  assign sd_mag[1] = sq_side[32][32:17];
  assign sd_mag[2] = sq_side[32][48:33];
  assign sd_neg    = sq_side[32][51:49];
  assign sd_ang    = sq_side[32][67:52];

  assign dv_vld[0]  = sq_vld[32];
  assign dv_len[0]  = sq_root[32];
  assign dv_quo[0]  = '0;
  assign dv_side[0] = {sd_ang, sd_neg, sd_zero};
  for (genvar l = 0; l < 3; l++) begin : g_num
    assign dv_rem[0][l] = (NW'(sd_mag[l]) << (FB + 16)) + NW'(sq_root[32] >> 1);
  end

  for (genvar d = 0; d <= FB; d++) begin : g_div
    aar_div_cell #(.K(FB - d), .FB(FB), .NW(NW), .SW(DSW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(dv_vld[d]), .len_i(dv_len[d]), .rem_i(dv_rem[d]), .quo_i(dv_quo[d]),
      .side_i(dv_side[d]),
      .vld_o(dv_vld[d+1]), .len_o(dv_len[d+1]), .rem_o(dv_rem[d+1]), .quo_o(dv_quo[d+1]),
      .side_o(dv_side[d+1])
    );
  end

  assign dd_neg = dv_side[FB+1][3:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_vld_r <= 1'b0;
    end else if (adv) begin
      u_vld_r <= dv_vld[FB+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        if (UW'(dv_quo[FB+1][l]) > UW'(ONE)) begin
          u_r[l] <= dd_neg[l] ? -UW'(ONE) : UW'(ONE);
        end else begin
          u_r[l] <= dd_neg[l] ? -UW'(dv_quo[FB+1][l]) : UW'(dv_quo[FB+1][l]);
        end
      end
      u_ang_r  <= dv_side[FB+1][19:4];
      u_zero_r <= dv_side[FB+1][0];
    end
  end

  // sine and cosine
  assign aq    = u_ang_r + 16'd8192;
  assign quad  = aq[15:14];
  assign resid = u_ang_r - {quad, 14'd0};

  assign cr_vld[0]  = u_vld_r;
  assign cr_x[0]    = X0;
  assign cr_y[0]    = '0;
  assign cr_z[0]    = {{(ZW - 32){resid[15]}}, resid, 16'd0};
  assign cr_side[0] = {quad, u_r[2], u_r[1], u_r[0], u_zero_r};

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    aar_cordic_cell #(.I(g), .XW(XW), .ZW(ZW), .SW(CSW + 2)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(cr_vld[g]), .x_i(cr_x[g]), .y_i(cr_y[g]), .z_i(cr_z[g]), .side_i(cr_side[g]),
      .vld_o(cr_vld[g+1]), .x_o(cr_x[g+1]), .y_o(cr_y[g+1]), .z_o(cr_z[g+1]),
      .side_o(cr_side[g+1])
    );
  end

  assign cq = cr_side[NS][CSW+1:CSW];

  always_comb begin
    case (cq)
      2'd0: begin
        cc = cr_x[NS];
        ss = cr_y[NS];
      end
      2'd1: begin
        cc = -cr_y[NS];
        ss = cr_x[NS];
      end
      2'd2: begin
        cc = -cr_x[NS];
        ss = -cr_y[NS];
      end
      default: begin
        cc = cr_y[NS];
        ss = -cr_x[NS];
      end
    endcase
    cl_c = (cc > ONE) ? ONE : ((cc < -ONE) ? -ONE : cc);
    cl_s = (ss > ONE) ? ONE : ((ss < -ONE) ? -ONE : ss);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_ctl_r <= '0;
    end else if (adv) begin
      q_ctl_r <= '{vld: cr_vld[NS], zero: cr_side[NS][0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_c_r <= UW'(cl_c);
      q_s_r <= UW'(cl_s);
      q_t_r <= (UW + 1)'(ONE - cl_c);
      q_x_r <= cr_side[NS][UW:1];
      q_y_r <= cr_side[NS][2*UW:UW+1];
      q_z_r <= cr_side[NS][3*UW:2*UW+1];
    end
  end

  aar_matrix #(.FB(FB), .UW(UW), .EW(EW)) u_matrix (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .ctl_i(q_ctl_r), .c_i(q_c_r), .s_i(q_s_r), .t_i(q_t_r),
    .x_i(q_x_r), .y_i(q_y_r), .z_i(q_z_r),
    .ctl_o(m_ctl), .el_o(m_el)
  );

  // requantize to q1.14 and clamp, identity matrix for a zero axis
  always_comb begin
    logic signed [63:0] v;
    for (int k = 0; k < 9; k++) begin
      v = rnd_shift(64'($signed(m_el[k])), RSH) <<< LSH;
      if (m_ctl.zero) begin
        res_nxt[k] = ((k % 4) == 0) ? 16'(Q14_ONE) : 16'sd0;
      end else if (v > 64'(Q14_ONE)) begin
        res_nxt[k] = 16'(Q14_ONE);
      end else if (v < -64'(Q14_ONE)) begin
        res_nxt[k] = -16'(Q14_ONE);
      end else begin
        res_nxt[k] = 16'(v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= m_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      for (int k = 0; k < 9; k++) begin
        res_r[k] <= res_nxt[k];
      end
      zero_out_r <= m_ctl.zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r00       = res_r[0];
  assign out_r01       = res_r[1];
  assign out_r02       = res_r[2];
  assign out_r10       = res_r[3];
  assign out_r11       = res_r[4];
  assign out_r12       = res_r[5];
  assign out_r20       = res_r[6];
  assign out_r21       = res_r[7];
  assign out_r22       = res_r[8];
  assign out_axis_zero = zero_out_r;
endmodule
`default_nettype wire

// ----- src/aar_checker.sv -----
// port-level checks for the rotation matrix block and their bind
`default_nettype none
module aar_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [15:0] out_r00,
  input wire signed [15:0] out_r01,
  input wire signed [15:0] out_r02,
  input wire signed [15:0] out_r11,
  input wire signed [15:0] out_r22,
  input wire               out_axis_zero
);
  import aar_pkg::*;

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_r00) && $stable(out_r01)
      && $stable(out_r22) && $stable(out_axis_zero))
    else $error("stalled result beat changed");

  // zero axis gives identity
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_axis_zero |-> out_r00 == 16'sd16384 && out_r11 == 16'sd16384
      && out_r22 == 16'sd16384 && out_r01 == 16'sd0 && out_r02 == 16'sd0)
    else $error("zero axis without identity");

  // elements r00, r01 and r22 stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_r00 <= 16'sd16384 && out_r00 >= -16'sd16384
      && out_r01 <= 16'sd16384 && out_r01 >= -16'sd16384
      && out_r22 <= 16'sd16384 && out_r22 >= -16'sd16384)
    else $error("matrix element out of range");
endmodule

bind axis_angle_rotation_matrix aar_checker u_aar_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_r00(out_r00), .out_r01(out_r01), .out_r02(out_r02), .out_r11(out_r11),
  .out_r22(out_r22), .out_axis_zero(out_axis_zero)
);
`default_nettype wire
